// File: sv/oets_pkg.sv
// ----------------------------------------------------------------------------
// oets_pkg
// Shared types and constants of the odd-even transposition sorter.
// ----------------------------------------------------------------------------
package oets_pkg;

	localparam int DATA_W        = 32;
	localparam int MAX_ITEMS_DEF = 32;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT_EVEN,
		ST_SORT_ODD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;   // store the input transfer
		logic sort;   // run one compare-and-swap phase
		logic odd;    // phase select: odd pairs when set
		logic emit;   // move the lowest element to the output register
	} cmd_t;

	typedef struct packed {
		logic swapped;    // current phase swaps at least one pair
		logic last_elem;  // one element left in the store
		logic out_free;   // output register can take an element
	} status_t;

endpackage

// File: sv/oets_in_if.sv
// ----------------------------------------------------------------------------
// oets_in_if
// Element channel: one signed value per transfer, last marks end of set.
// ----------------------------------------------------------------------------
interface oets_in_if;

	logic                              valid;
	logic                              ready;
	logic signed [oets_pkg::DATA_W-1:0] value;
	logic                              last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);

endinterface

// File: sv/oets_out_if.sv
// ----------------------------------------------------------------------------
// oets_out_if
// Result channel: sorted values in ascending order with end and drop marks.
// ----------------------------------------------------------------------------
interface oets_out_if;

	logic                              valid;
	logic                              ready;
	logic signed [oets_pkg::DATA_W-1:0] sorted_value;
	logic                              last_out;
	logic                              overflowed;

	modport source (output valid, output sorted_value, output last_out, output overflowed,
		input ready);
	modport sink   (input valid, input sorted_value, input last_out, input overflowed,
		output ready);

endinterface

// File: sv/oets_ctrl.sv
// ----------------------------------------------------------------------------
// oets_ctrl
// Sequencer: load, alternating even/odd sort phases, emission.
// ----------------------------------------------------------------------------
module oets_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  oets_pkg::status_t status,
	output oets_pkg::cmd_t    cmd
);

	oets_pkg::state_t state_q, state_d;
	logic             even_swap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= oets_pkg::ST_LOAD;
			even_swap_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == oets_pkg::ST_SORT_EVEN) begin
				even_swap_q <= status.swapped;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oets_pkg::ST_LOAD: begin
				if (in_valid && in_last) begin
					state_d = oets_pkg::ST_SORT_EVEN;
				end
			end
			oets_pkg::ST_SORT_EVEN: begin
				state_d = oets_pkg::ST_SORT_ODD;
			end
			oets_pkg::ST_SORT_ODD: begin
				if (even_swap_q || status.swapped) begin
					state_d = oets_pkg::ST_SORT_EVEN;
				end else begin
					state_d = oets_pkg::ST_EMIT;
				end
			end
			oets_pkg::ST_EMIT: begin
				if (status.out_free && status.last_elem) begin
					state_d = oets_pkg::ST_LOAD;
				end
			end
			default: state_d = oets_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			oets_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			oets_pkg::ST_SORT_EVEN: begin
				cmd.sort = 1'b1;
			end
			oets_pkg::ST_SORT_ODD: begin
				cmd.sort = 1'b1;
				cmd.odd  = 1'b1;
			end
			oets_pkg::ST_EMIT: begin
				cmd.emit = status.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// File: sv/oets_datapath.sv
// ----------------------------------------------------------------------------
// oets_datapath
// Element row with neighbor compare-and-swap cells, count, drop flag and
// output register. Emission shifts the row down by one element.
// ----------------------------------------------------------------------------
module oets_datapath #(
	parameter int MAX_ITEMS = oets_pkg::MAX_ITEMS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  oets_pkg::cmd_t                      cmd,
	output oets_pkg::status_t                   status,
	input  logic signed [oets_pkg::DATA_W-1:0]  value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [oets_pkg::DATA_W-1:0]  sorted_value,
	output logic                                last_out,
	output logic                                overflowed
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int IW = $clog2(MAX_ITEMS);

	logic signed [oets_pkg::DATA_W-1:0] elem_q [MAX_ITEMS];
	logic signed [oets_pkg::DATA_W-1:0] elem_d [MAX_ITEMS];
	logic [MAX_ITEMS-2:0]               swap;
	logic [CW-1:0]                      count_q;
	logic                               dropped_q;
	logic                               has_room;

	assign has_room = count_q < CW'(MAX_ITEMS);

	for (genvar i = 0; i < MAX_ITEMS - 1; i++) begin : g_pair
		localparam logic [CW-1:0] UPPER = CW'(i + 1);
		localparam bit            ODD_I = (i % 2) == 1;
		assign swap[i] = (cmd.odd == ODD_I) && (UPPER < count_q) && (elem_q[i] > elem_q[i + 1]);
	end

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_elem
		localparam logic [IW-1:0] IDX = IW'(i);
		logic signed [oets_pkg::DATA_W-1:0] sorted_e;
		logic signed [oets_pkg::DATA_W-1:0] shifted_e;

		if (i == 0) begin : g_first
			assign sorted_e  = swap[i] ? elem_q[i + 1] : elem_q[i];
			assign shifted_e = elem_q[i + 1];
		end else if (i == MAX_ITEMS - 1) begin : g_final
			assign sorted_e  = swap[i - 1] ? elem_q[i - 1] : elem_q[i];
			assign shifted_e = elem_q[i];
		end else begin : g_mid
			assign sorted_e  = swap[i] ? elem_q[i + 1] :
				(swap[i - 1] ? elem_q[i - 1] : elem_q[i]);
			assign shifted_e = elem_q[i + 1];
		end

		always_comb begin
			priority if (cmd.load && has_room && (count_q[IW-1:0] == IDX)) begin
				elem_d[i] = value;
			end else if (cmd.sort) begin
				elem_d[i] = sorted_e;
			end else if (cmd.emit) begin
				elem_d[i] = shifted_e;
			end else begin
				elem_d[i] = elem_q[i];
			end
		end

		always_ff @(posedge clk) begin
			elem_q[i] <= elem_d[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (has_room) begin
					count_q <= count_q + CW'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end else if (cmd.emit) begin
				count_q <= count_q - CW'(1);
				if (status.last_elem) begin
					dropped_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			sorted_value <= elem_q[0];
			last_out     <= status.last_elem;
			overflowed   <= dropped_q;
		end
	end

	assign status.swapped   = |swap;
	assign status.last_elem = count_q == CW'(1);
	assign status.out_free  = !out_valid || out_ready;

endmodule

// File: sv/odd_even_transposition_sort_unit.sv
// ----------------------------------------------------------------------------
// odd_even_transposition_sort_unit
// Collects a set of signed values, sorts it ascending by odd-even
// transposition and sends the sorted set out.
//
// elements: one value per transfer; last closes the set. Ready is high only
//   while loading, one transfer per cycle. Values beyond MAX_ITEMS are
//   dropped and every result of that set carries overflowed.
// results: the set in ascending order, last_out on the final value.
// Sequence for a set of stored values: loading, then sort phases at
//   one phase per cycle over all neighbor pairs at once (even, odd, ...),
//   in even/odd rounds until a round makes no swap. Emission then follows,
//   loading the output register with one result per cycle while
//   results.ready stays high.
// A stalled receiver holds the output register; the row shifts only when
//   the register is taken. The next set can load while the final result
//   still waits.
// Reset clears the count, drop flag, output valid and sequencer; stored
//   values are not cleared.
// ----------------------------------------------------------------------------
module odd_even_transposition_sort_unit #(
	parameter int MAX_ITEMS = oets_pkg::MAX_ITEMS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	oets_in_if.sink     elements,
	oets_out_if.source  results
);

	oets_pkg::cmd_t    cmd;
	oets_pkg::status_t status;

	oets_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (elements.valid),
		.in_last  (elements.last),
		.in_ready (elements.ready),
		.status   (status),
		.cmd      (cmd)
	);

	oets_datapath #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.value        (elements.value),
		.out_valid    (results.valid),
		.out_ready    (results.ready),
		.sorted_value (results.sorted_value),
		.last_out     (results.last_out),
		.overflowed   (results.overflowed)
	);

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.sort, cmd.emit}))
		else $error("more than one datapath command at once");

	a_no_load_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !elements.ready)
		else $error("element transfer possible during emission");

	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && status.last_elem |=> elements.ready)
		else $error("not back to loading after the final result");

	a_sort_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sort |-> !elements.ready && !cmd.emit)
		else $error("sort phase overlaps load or emission");

endmodule
